FILE: hdl/prpu_pkg.sv
`default_nettype none
package prpu_pkg;

	localparam int INDEX_WIDTH = 24;
	localparam int BASE_W      = 24;
	localparam int TGT_W       = 25;
	localparam int ACC_W       = 14;
	localparam int IDX_OUT_W   = 24;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_RANGE = 2'd1;
	localparam logic [1:0] KIND_SPLIT = 2'd2;

	typedef enum logic [2:0] {
		PH_TYPE = 3'd0,
		PH_LOW  = 3'd1,
		PH_HIGH = 3'd2,
		PH_TGT1 = 3'd3,
		PH_TGT2 = 3'd4
	} phase_t;

endpackage
`default_nettype wire

FILE: hdl/prpu_cfg_if.sv
`default_nettype none
interface prpu_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [prpu_pkg::BASE_W-1:0] base_offset;

	modport source (output valid, output base_offset, input ready);
	modport sink   (input valid, input base_offset, output ready);
endinterface
`default_nettype wire

FILE: hdl/prpu_in_if.sv
`default_nettype none
interface prpu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, output data_byte, output end_of_stream, input ready);
	modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface
`default_nettype wire

FILE: hdl/prpu_out_if.sv
`default_nettype none
interface prpu_out_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     kind;
	logic [7:0]                     low_byte;
	logic [7:0]                     high_byte;
	logic [prpu_pkg::TGT_W-1:0]     first_target;
	logic                           first_open;
	logic [prpu_pkg::TGT_W-1:0]     second_target;
	logic                           second_open;
	logic [prpu_pkg::IDX_OUT_W-1:0] inst_index;
	logic                           format_error;
	logic                           stream_done;

	modport source (
		output valid, output kind, output low_byte, output high_byte,
		output first_target, output first_open, output second_target,
		output second_open, output inst_index, output format_error,
		output stream_done, input ready
	);
	modport sink (
		input valid, input kind, input low_byte, input high_byte,
		input first_target, input first_open, input second_target,
		input second_open, input inst_index, input format_error,
		input stream_done, output ready
	);
endinterface
`default_nettype wire

FILE: hdl/packed_regex_program_unpacker.sv
`default_nettype none
// Unpacks a packed regex program byte stream, one byte per word on byte_stream,
// into one decoded instruction word per record on inst_stream. A byte is taken
// every cycle as long as the result register is empty or being drained in the
// same cycle, so throughput is one byte per clock; the instruction for the
// byte that completes a record shows in the next cycle (the result register).
// Records: type 0 byte match (value, target), 1 range (low, high, target),
// 2 split (target, target). Targets are big-endian 7-bit varints of at most
// two bytes; a zero target comes out open, any other gets base_offset added.
// A bad type, a third target byte or an end mark inside a record gives one
// error word with stream_done set; bytes after it are dropped up to and
// including the next end mark. base_offset is written on cfg, which is always
// ready, and must only be changed while no stream is in flight.
module packed_regex_program_unpacker (
	input  wire               clk,
	input  wire               arst_n,
	prpu_cfg_if.sink          cfg,
	prpu_in_if.sink           byte_stream,
	prpu_out_if.source        inst_stream
);

	localparam int IW    = prpu_pkg::INDEX_WIDTH;
	localparam int SUM_W = (IW > prpu_pkg::IDX_OUT_W) ? IW : prpu_pkg::IDX_OUT_W;
	localparam logic [SUM_W-1:0] IDX_MASK = SUM_W'((65'd1 << IW) - 65'd1);

	// configuration
	logic [prpu_pkg::BASE_W-1:0] base_q;

	// parse state
	prpu_pkg::phase_t               phase_q, phase_d;
	logic [1:0]                     kind_q, kind_d;
	logic [7:0]                     low_q, low_d;
	logic [7:0]                     high_q, high_d;
	logic [prpu_pkg::ACC_W-1:0]     acc_q, acc_d;
	logic [1:0]                     seen_q, seen_d;
	logic [prpu_pkg::TGT_W-1:0]     ft_q, ft_d;
	logic                           fo_q, fo_d;
	logic [IW-1:0]                  count_q, count_d;
	logic                           disc_q, disc_d;

	// result register
	logic                           out_valid_q;
	logic [1:0]                     r_kind_q;
	logic [7:0]                     r_low_q, r_high_q;
	logic [prpu_pkg::TGT_W-1:0]     r_ft_q, r_st_q;
	logic                           r_fo_q, r_so_q;
	logic [prpu_pkg::IDX_OUT_W-1:0] r_idx_q;
	logic                           r_err_q, r_done_q;

	// decode of the incoming byte
	logic                           accept;
	logic [7:0]                     b;
	logic                           eos;
	logic [prpu_pkg::ACC_W-1:0]     acc_nx;
	logic                           t_zero;
	logic [prpu_pkg::TGT_W-1:0]     t_res;
	logic                           err;
	logic                           emit;
	logic [SUM_W-1:0]               idx_sum;

	// result payload
	logic [1:0]                     o_kind;
	logic [7:0]                     o_low, o_high;
	logic [prpu_pkg::TGT_W-1:0]     o_ft, o_st;
	logic                           o_fo, o_so;
	logic [prpu_pkg::IDX_OUT_W-1:0] o_idx;

	// the result register frees up when empty or drained this cycle
	assign byte_stream.ready = !out_valid_q || inst_stream.ready;
	assign accept            = byte_stream.valid && byte_stream.ready;
	assign cfg.ready         = 1'b1;

	assign b   = byte_stream.data_byte;
	assign eos = byte_stream.end_of_stream;

	// next 7-bit group shifted into the target accumulator
	assign acc_nx = {acc_q[6:0], b[6:0]};
	assign t_zero = (acc_nx == '0);
	assign t_res  = t_zero ? '0
		: prpu_pkg::TGT_W'(acc_nx) + prpu_pkg::TGT_W'(base_q);

	// program index wraps at the index width, then shows its low 24 bits
	assign idx_sum = (SUM_W'(base_q) + SUM_W'(count_q) + SUM_W'(1)) & IDX_MASK;
	assign o_idx   = prpu_pkg::IDX_OUT_W'(idx_sum);

	// error and emit decisions for this byte
	always_comb begin
		err  = 1'b0;
		emit = 1'b0;
		if (!disc_q) begin
			unique case (phase_q) inside
				prpu_pkg::PH_TYPE: err = (b > 8'(prpu_pkg::KIND_SPLIT)) || eos;
				prpu_pkg::PH_LOW,
				prpu_pkg::PH_HIGH: err = eos;
				prpu_pkg::PH_TGT1,
				prpu_pkg::PH_TGT2: begin
					if (seen_q >= 2'd2) begin
						// any byte after two continuation bytes: over-long target
						err = 1'b1;
					end else if (b[7]) begin
						err = eos;
					end else if (phase_q == prpu_pkg::PH_TGT2 ||
					             kind_q != prpu_pkg::KIND_SPLIT) begin
						emit = 1'b1;
					end else begin
						err = eos;
					end
				end
				default: err = 1'b1;
			endcase
		end
	end

	// instruction fields; a single-target record resolves its target now
	always_comb begin
		o_kind = kind_q;
		o_low  = (kind_q == prpu_pkg::KIND_SPLIT) ? 8'd0 : low_q;
		case (kind_q)
			prpu_pkg::KIND_RANGE: o_high = high_q;
			prpu_pkg::KIND_BYTE:  o_high = low_q;
			default:              o_high = 8'd0;
		endcase
		if (phase_q == prpu_pkg::PH_TGT2) begin
			o_ft = ft_q;
			o_fo = fo_q;
			o_st = t_res;
			o_so = t_zero;
		end else begin
			o_ft = t_res;
			o_fo = t_zero;
			o_st = '0;
			o_so = 1'b0;
		end
	end

	// next parse state
	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		low_d   = low_q;
		high_d  = high_q;
		acc_d   = acc_q;
		seen_d  = seen_q;
		ft_d    = ft_q;
		fo_d    = fo_q;
		count_d = count_q;
		disc_d  = disc_q;
		if (disc_q || err || emit) begin
			// record or stream finished: back to a type byte
			phase_d = prpu_pkg::PH_TYPE;
			kind_d  = '0;
			low_d   = '0;
			high_d  = '0;
			acc_d   = '0;
			seen_d  = '0;
			ft_d    = '0;
			fo_d    = 1'b0;
			if (disc_q) begin
				if (eos) begin
					disc_d  = 1'b0;
					count_d = '0;
				end else begin
					// still dropping: hold the parse state and the drop flag as they are
					phase_d = phase_q;
					kind_d  = kind_q;
					low_d   = low_q;
					high_d  = high_q;
					acc_d   = acc_q;
					seen_d  = seen_q;
					ft_d    = ft_q;
					fo_d    = fo_q;
				end
			end else if (err) begin
				count_d = '0;
				disc_d  = !eos;
			end else begin
				count_d = eos ? '0 : count_q + IW'(1);
			end
		end else begin
			unique case (phase_q) inside
				prpu_pkg::PH_TYPE: begin
					kind_d  = b[1:0];
					phase_d = (b[1:0] == prpu_pkg::KIND_SPLIT) ? prpu_pkg::PH_TGT1
						: prpu_pkg::PH_LOW;
				end
				prpu_pkg::PH_LOW: begin
					low_d   = b;
					phase_d = (kind_q == prpu_pkg::KIND_RANGE) ? prpu_pkg::PH_HIGH
						: prpu_pkg::PH_TGT1;
				end
				prpu_pkg::PH_HIGH: begin
					high_d  = b;
					phase_d = prpu_pkg::PH_TGT1;
				end
				prpu_pkg::PH_TGT1,
				prpu_pkg::PH_TGT2: begin
					if (b[7]) begin
						acc_d  = acc_nx;
						seen_d = seen_q + 2'd1;
					end else begin
						// first target of a split: hold it, go for the second
						ft_d    = t_res;
						fo_d    = t_zero;
						acc_d   = '0;
						seen_d  = '0;
						phase_d = prpu_pkg::PH_TGT2;
					end
				end
				default: phase_d = prpu_pkg::PH_TYPE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			phase_q     <= prpu_pkg::PH_TYPE;
			kind_q      <= '0;
			low_q       <= '0;
			high_q      <= '0;
			acc_q       <= '0;
			seen_q      <= '0;
			ft_q        <= '0;
			fo_q        <= 1'b0;
			count_q     <= '0;
			disc_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				base_q <= cfg.base_offset;
			end
			if (accept) begin
				phase_q <= phase_d;
				kind_q  <= kind_d;
				low_q   <= low_d;
				high_q  <= high_d;
				acc_q   <= acc_d;
				seen_q  <= seen_d;
				ft_q    <= ft_d;
				fo_q    <= fo_d;
				count_q <= count_d;
				disc_q  <= disc_d;
			end
			if (accept && (err || emit)) begin
				out_valid_q <= 1'b1;
			end else if (inst_stream.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded only with a fresh word
	always_ff @(posedge clk) begin
		if (accept && (err || emit)) begin
			if (err) begin
				// error word: everything zero but the two flags
				r_kind_q <= '0;
				r_low_q  <= '0;
				r_high_q <= '0;
				r_ft_q   <= '0;
				r_fo_q   <= 1'b0;
				r_st_q   <= '0;
				r_so_q   <= 1'b0;
				r_idx_q  <= '0;
				r_err_q  <= 1'b1;
				r_done_q <= 1'b1;
			end else begin
				r_kind_q <= o_kind;
				r_low_q  <= o_low;
				r_high_q <= o_high;
				r_ft_q   <= o_ft;
				r_fo_q   <= o_fo;
				r_st_q   <= o_st;
				r_so_q   <= o_so;
				r_idx_q  <= o_idx;
				r_err_q  <= 1'b0;
				r_done_q <= eos;
			end
		end
	end

	assign inst_stream.valid         = out_valid_q;
	assign inst_stream.kind          = r_kind_q;
	assign inst_stream.low_byte      = r_low_q;
	assign inst_stream.high_byte     = r_high_q;
	assign inst_stream.first_target  = r_ft_q;
	assign inst_stream.first_open    = r_fo_q;
	assign inst_stream.second_target = r_st_q;
	assign inst_stream.second_open   = r_so_q;
	assign inst_stream.inst_index    = r_idx_q;
	assign inst_stream.format_error  = r_err_q;
	assign inst_stream.stream_done   = r_done_q;

endmodule
`default_nettype wire

FILE: hdl/prpu_checker.sv
`default_nettype none
module prpu_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_ready,
	input wire                           out_valid,
	input wire                           out_ready,
	input wire [1:0]                     kind,
	input wire [7:0]                     low_byte,
	input wire [7:0]                     high_byte,
	input wire [prpu_pkg::TGT_W-1:0]     first_target,
	input wire                           first_open,
	input wire [prpu_pkg::TGT_W-1:0]     second_target,
	input wire                           second_open,
	input wire [prpu_pkg::IDX_OUT_W-1:0] inst_index,
	input wire                           format_error,
	input wire                           stream_done
);

	// a word waiting at the output stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(inst_index)
			&& $stable(first_target) && $stable(second_target) && $stable(format_error))
		else $error("output word changed while stalled");

	// an empty result register never blocks the byte side, and a new byte is
	// taken while a word waits only if that word drains now
	a_in_side: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid || in_ready) && (!(in_valid && in_ready && out_valid) || out_ready))
		else $error("byte stream handshake inconsistent with result register");

	// error words close the stream and carry nothing else
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format_error |-> stream_done && kind == 2'd0 && low_byte == 8'd0
			&& high_byte == 8'd0 && first_target == '0 && !first_open
			&& second_target == '0 && !second_open && inst_index == '0)
		else $error("malformed error word");

	// instruction kind agrees with its byte and second-target fields
	a_kind_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !format_error |->
			(kind == prpu_pkg::KIND_BYTE && high_byte == low_byte && second_target == '0
				&& !second_open)
			|| (kind == prpu_pkg::KIND_RANGE && second_target == '0 && !second_open)
			|| (kind == prpu_pkg::KIND_SPLIT && low_byte == 8'd0 && high_byte == 8'd0))
		else $error("instruction fields inconsistent with kind");

	// an open target always reads as zero
	a_open_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (first_open || second_open) |->
			(!first_open || first_target == '0) && (!second_open || second_target == '0))
		else $error("open target not zero");

endmodule

bind packed_regex_program_unpacker prpu_checker u_prpu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (byte_stream.valid),
	.in_ready      (byte_stream.ready),
	.out_valid     (inst_stream.valid),
	.out_ready     (inst_stream.ready),
	.kind          (inst_stream.kind),
	.low_byte      (inst_stream.low_byte),
	.high_byte     (inst_stream.high_byte),
	.first_target  (inst_stream.first_target),
	.first_open    (inst_stream.first_open),
	.second_target (inst_stream.second_target),
	.second_open   (inst_stream.second_open),
	.inst_index    (inst_stream.inst_index),
	.format_error  (inst_stream.format_error),
	.stream_done   (inst_stream.stream_done)
);
`default_nettype wire
